// ----- src/input_capture_edge_timestamp_unit_macros.svh -----
// Assertion helpers for the capture unit checker.
`ifndef INPUT_CAPTURE_EDGE_TIMESTAMP_UNIT_MACROS_SVH
`define INPUT_CAPTURE_EDGE_TIMESTAMP_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ICT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define ICT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ict_pkg.sv -----
package ict_pkg;

  localparam int CHANNEL_COUNT_DEF = 8;
  localparam int RING_DEPTH_DEF    = 16;

  // Request kinds
  localparam logic [1:0] KIND_EDGE  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Register addresses
  localparam logic [2:0] ADDR_CONTROL  = 3'd0;
  localparam logic [2:0] ADDR_STATE    = 3'd1;
  localparam logic [2:0] ADDR_EDGE_CNT = 3'd2;
  localparam logic [2:0] ADDR_TS_INDEX = 3'd3;
  localparam logic [2:0] ADDR_ELAPSED  = 3'd4;
  localparam logic [2:0] ADDR_LEVEL    = 3'd5;
  localparam logic [2:0] ADDR_TS_ENTRY = 3'd6;

  // Control bit positions
  localparam int CTL_COUNT_BIT = 2;
  localparam int CTL_TSRUN_BIT = 3;
  localparam int CTL_MEAS_BIT  = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE    = 1'd1;
  localparam int CFG_DATA_W = 5;

  localparam logic [4:0] RING_SIZE_RST = 5'd16;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] channel;
    logic [2:0] reg_addr;
    logic [4:0] write_data;
    logic [3:0] entry_index;
  } item_t;

  typedef struct packed {
    logic [4:0]  ctl;
    logic        active;
    logic [31:0] edge_cnt;
    logic [4:0]  ring_pos;
    logic [31:0] elapsed;
    logic        level;
  } chan_rec_t;

  typedef struct packed {
    logic rec_we;
    logic ts_we;
    logic tick_inc;
  } exec_ctl_t;

endpackage

// ----- src/ict_ifs.sv -----
interface ict_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] channel;
  logic [2:0] reg_addr;
  logic [4:0] write_data;
  logic [3:0] entry_index;

  modport source (output valid, kind, channel, reg_addr, write_data, entry_index,
                  input ready);
  modport sink (input valid, kind, channel, reg_addr, write_data, entry_index,
                output ready);
endinterface

interface ict_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        error;

  modport source (output valid, read_data, error, input ready);
  modport sink (input valid, read_data, error, output ready);
endinterface

interface ict_cfg_if;
  import ict_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/input_capture_edge_timestamp_unit.sv -----
// Multi-channel input capture unit: edge counting, per-channel timestamp rings
// and elapsed-time latching against a global tick that advances on each edge
// not rejected with an error. Takes one request per clock unless the response
// side stalls; each request gives one response via the s1 and output registers.
// The channel record and the timestamp ring are read at acceptance with a bypass
// from the write-back of the request ahead, which sets the one-request-per-cycle
// pace. Channel state comes out of reset cleared; timestamp entries hold nothing
// meaningful until an edge writes them. Configuration writes are taken at once.
module input_capture_edge_timestamp_unit #(
  parameter int CHANNEL_COUNT = ict_pkg::CHANNEL_COUNT_DEF,
  parameter int RING_DEPTH    = ict_pkg::RING_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst,
  ict_item_if.sink     item,
  ict_result_if.source result,
  ict_cfg_if.sink      cfg
);
  import ict_pkg::*;

  localparam int CW = CHANNEL_COUNT > 1 ? $clog2(CHANNEL_COUNT) : 1;
  localparam int RW = RING_DEPTH > 1 ? $clog2(RING_DEPTH) : 1;

  logic        block_enable;
  logic [4:0]  ring_size_cfg;
  logic [31:0] tick;

  logic        in_acc;
  logic        s1_valid;
  logic        s1_adv;
  item_t       s1_item;

  logic        out_valid;
  logic [31:0] out_data;
  logic        out_err;

  chan_rec_t   rec;
  chan_rec_t   rec_new;
  exec_ctl_t   ex_ctl;
  logic [4:0]  ts_pos;
  logic [31:0] ts_data;
  logic [31:0] ex_data;
  logic        ex_err;

  assign s1_adv     = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || s1_adv;
  assign in_acc     = item.valid && item.ready;

  assign result.valid     = out_valid;
  assign result.read_data = out_data;
  assign result.error     = out_err;
  assign cfg.ready        = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_enable  <= 1'b1;
      ring_size_cfg <= RING_SIZE_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_BLOCK_ENABLE: block_enable  <= cfg.data[0];
        CFG_RING_SIZE:    ring_size_cfg <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item <= '{kind: item.kind, channel: item.channel, reg_addr: item.reg_addr,
                   write_data: item.write_data, entry_index: item.entry_index};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick <= '0;
    end else if (s1_adv && ex_ctl.tick_inc) begin
      tick <= tick + 32'd1;
    end
  end

  ict_chan_state #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_chan_state (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (in_acc),
    .rd_ch  (CW'(item.channel)),
    .wr_en  (s1_adv && ex_ctl.rec_we),
    .wr_ch  (CW'(s1_item.channel)),
    .wr_rec (rec_new),
    .rd_rec (rec)
  );

  ict_ts_ram #(
    .AW(CW + RW)
  ) u_ts_ram (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr ({CW'(item.channel), RW'(item.entry_index)}),
    .wr_en   (s1_adv && ex_ctl.ts_we),
    .wr_addr ({CW'(s1_item.channel), RW'(ts_pos)}),
    .wr_data (tick),
    .rd_data (ts_data)
  );

  ict_exec #(
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .RING_DEPTH   (RING_DEPTH)
  ) u_exec (
    .it            (s1_item),
    .rec           (rec),
    .ts_data       (ts_data),
    .tick          (tick),
    .block_enable  (block_enable),
    .ring_size_cfg (ring_size_cfg),
    .rec_new       (rec_new),
    .ctl           (ex_ctl),
    .ts_pos        (ts_pos),
    .read_data     (ex_data),
    .error         (ex_err)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data <= ex_data;
      out_err  <= ex_err;
    end
  end

endmodule

// ----- src/ict_chan_state.sv -----
module ict_chan_state #(
  parameter int CHANNEL_COUNT = ict_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [(CHANNEL_COUNT > 1 ? $clog2(CHANNEL_COUNT) : 1)-1:0] rd_ch,
  input  logic                wr_en,
  input  logic [(CHANNEL_COUNT > 1 ? $clog2(CHANNEL_COUNT) : 1)-1:0] wr_ch,
  input  ict_pkg::chan_rec_t  wr_rec,
  output ict_pkg::chan_rec_t  rd_rec
);
  import ict_pkg::*;

  localparam int CW    = CHANNEL_COUNT > 1 ? $clog2(CHANNEL_COUNT) : 1;
  localparam int ROWS  = 2 ** CW;

  chan_rec_t         mem [ROWS];
  logic [ROWS-1:0]   vld;

  // a row never written reads as its reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_ch] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ch] <= wr_rec;
    end
  end

  // bypass the write-back of the request ahead
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && wr_ch == rd_ch) begin
        rd_rec <= wr_rec;
      end else if (vld[rd_ch]) begin
        rd_rec <= mem[rd_ch];
      end else begin
        rd_rec <= '0;
      end
    end
  end

endmodule

// ----- src/ict_ts_ram.sv -----
module ict_ts_ram #(
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && wr_addr == rd_addr) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// ----- src/ict_exec.sv -----
module ict_exec #(
  parameter int CHANNEL_COUNT = ict_pkg::CHANNEL_COUNT_DEF,
  parameter int RING_DEPTH    = ict_pkg::RING_DEPTH_DEF
) (
  input  ict_pkg::item_t     it,
  input  ict_pkg::chan_rec_t rec,
  input  logic [31:0]        ts_data,
  input  logic [31:0]        tick,
  input  logic               block_enable,
  input  logic [4:0]         ring_size_cfg,
  output ict_pkg::chan_rec_t rec_new,
  output ict_pkg::exec_ctl_t ctl,
  output logic [4:0]         ts_pos,
  output logic [31:0]        read_data,
  output logic               error
);
  import ict_pkg::*;

  logic       ok_ch;
  logic       level_write;
  logic [4:0] size;
  logic [4:0] pos;

  assign ok_ch       = 32'(it.channel) < CHANNEL_COUNT;
  assign level_write = it.kind == KIND_WRITE && it.reg_addr == ADDR_LEVEL;

  always_comb begin
    if (ring_size_cfg == '0) begin
      size = 5'd1;
    end else if (32'(ring_size_cfg) > RING_DEPTH) begin
      size = 5'(RING_DEPTH);
    end else begin
      size = ring_size_cfg;
    end
    pos = (rec.ring_pos >= size) ? 5'd0 : rec.ring_pos;
  end

  always_comb begin
    rec_new   = rec;
    ctl       = '0;
    ts_pos    = pos;
    read_data = '0;
    error     = 1'b0;
    if (it.kind == KIND_EDGE || it.kind == KIND_WRITE || it.kind == KIND_READ) begin
      if (!ok_ch || (!block_enable && !level_write)) begin
        error = 1'b1;
      end else begin
        unique case (it.kind)
          KIND_EDGE: begin
            ctl.rec_we     = 1'b1;
            ctl.tick_inc   = 1'b1;
            rec_new.active = 1'b1;
            if (rec.ctl[CTL_COUNT_BIT]) begin
              rec_new.edge_cnt = rec.edge_cnt + 32'd1;
            end
            if (rec.ctl[CTL_TSRUN_BIT]) begin
              ctl.ts_we        = 1'b1;
              rec_new.ring_pos = pos + 5'd1;
            end
            if (rec.ctl[CTL_MEAS_BIT]) begin
              rec_new.elapsed = tick;
            end
          end
          KIND_WRITE: begin
            ctl.rec_we = 1'b1;
            case (it.reg_addr)
              ADDR_CONTROL: begin
                rec_new.ctl = it.write_data;
                if (it.write_data[CTL_TSRUN_BIT]) begin
                  rec_new.ring_pos = '0;
                end
                if (it.write_data[CTL_MEAS_BIT]) begin
                  rec_new.elapsed = '0;
                end
              end
              ADDR_EDGE_CNT: rec_new.edge_cnt = '0;
              ADDR_LEVEL:    rec_new.level = it.write_data[0];
              default: ;
            endcase
          end
          default: begin
            case (it.reg_addr)
              ADDR_CONTROL: read_data = 32'(rec.ctl);
              ADDR_STATE: begin
                read_data      = 32'(rec.active);
                rec_new.active = 1'b0;
                ctl.rec_we     = 1'b1;
              end
              ADDR_EDGE_CNT: read_data = rec.edge_cnt;
              ADDR_TS_INDEX: read_data = 32'(rec.ring_pos);
              ADDR_ELAPSED:  read_data = rec.elapsed;
              ADDR_LEVEL:    read_data = 32'(rec.level);
              ADDR_TS_ENTRY: begin
                if (32'(it.entry_index) < RING_DEPTH) begin
                  read_data = ts_data;
                end
              end
              default: ;
            endcase
          end
        endcase
      end
    end
  end

endmodule

// ----- src/ict_checker.sv -----
`include "input_capture_edge_timestamp_unit_macros.svh"

module ict_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] res_data,
  input logic        res_error
);

  // a stalled response keeps its valid and its data
  `ICT_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_data) && $stable(res_error), "response changed while stalled")

  // a rejected request never carries read data
  `ICT_ASSERT_NOW(a_err_zero, clk, rst, res_valid && res_error, res_data == 32'd0, "error response with nonzero data")

  // request side only stalls when both stages are full and the response waits
  `ICT_ASSERT_NOW(a_stall_cause, clk, rst, !item_ready, res_valid && !res_ready, "request stalled with a free response slot")

endmodule

bind input_capture_edge_timestamp_unit ict_checker u_ict_checker (
  .clk        (clk),
  .rst        (rst),
  .item_ready (item.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_data   (result.read_data),
  .res_error  (result.error)
);

// ----- bench/testbench.sv -----
module testbench;
  import ict_pkg::*;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam logic [2:0] ADDR_UNUSED  = 3'd7;
  localparam int         CHANNELS     = CHANNEL_COUNT_DEF;
  localparam int         RING_ENTRIES = RING_DEPTH_DEF;
  localparam int         STALL_LIMIT  = 3000;
  localparam int         DRAIN_CYCLES = 8;

  typedef struct {
    logic [31:0] read_data;
    logic        error;
  } capture_result_t;

  logic clk;
  logic rst;

  ict_item_if   item_if();
  ict_result_if result_if();
  ict_cfg_if    cfg_if();

  input_capture_edge_timestamp_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  // predicted state of the capture unit
  logic        cfg_enable;
  logic [4:0]  cfg_ring_size;
  logic [4:0]  chan_ctl      [CHANNELS];
  logic        chan_active   [CHANNELS];
  logic [31:0] chan_edges    [CHANNELS];
  logic [4:0]  chan_ring_pos [CHANNELS];
  logic [31:0] chan_elapsed  [CHANNELS];
  logic        chan_level    [CHANNELS];
  logic [31:0] stamp_mem     [CHANNELS][RING_ENTRIES];
  bit          stamp_written [CHANNELS][RING_ENTRIES];
  logic [31:0] global_tick;

  capture_result_t pending_results[$];
  int failures;
  bit no_idle;
  int hold_request;
  int focus_channel;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic capture_result_t predict_capture(item_t req);
    capture_result_t res;
    int ch;
    logic [4:0] size;
    logic [4:0] pos;
    bit level_write;
    res.read_data = '0;
    res.error     = 1'b0;
    ch = req.channel;
    level_write = (req.kind == KIND_WRITE) && (req.reg_addr == ADDR_LEVEL);
    if (req.kind == KIND_UNUSED) begin
      // unknown kind: no effect, no error
    end else if (req.channel >= CHANNELS || (!cfg_enable && !level_write)) begin
      res.error = 1'b1;
    end else if (req.kind == KIND_EDGE) begin
      chan_active[ch] = 1'b1;
      if (chan_ctl[ch][CTL_COUNT_BIT]) chan_edges[ch] = chan_edges[ch] + 32'd1;
      if (chan_ctl[ch][CTL_TSRUN_BIT]) begin
        size = cfg_ring_size;
        if (size == 5'd0) size = 5'd1;
        if (size > RING_ENTRIES) size = 5'(RING_ENTRIES);
        pos = chan_ring_pos[ch];
        if (pos >= size) pos = '0;
        stamp_mem[ch][pos]     = global_tick;
        stamp_written[ch][pos] = 1'b1;
        chan_ring_pos[ch]      = pos + 5'd1;
      end
      if (chan_ctl[ch][CTL_MEAS_BIT]) chan_elapsed[ch] = global_tick;
      global_tick = global_tick + 32'd1;
    end else if (req.kind == KIND_WRITE) begin
      case (req.reg_addr)
        ADDR_CONTROL: begin
          chan_ctl[ch] = req.write_data;
          if (req.write_data[CTL_TSRUN_BIT]) chan_ring_pos[ch] = '0;
          if (req.write_data[CTL_MEAS_BIT]) chan_elapsed[ch] = '0;
        end
        ADDR_EDGE_CNT: chan_edges[ch] = '0;
        ADDR_LEVEL:    chan_level[ch] = req.write_data[0];
        default: ;
      endcase
    end else begin
      case (req.reg_addr)
        ADDR_CONTROL: res.read_data = 32'(chan_ctl[ch]);
        ADDR_STATE: begin
          res.read_data   = 32'(chan_active[ch]);
          chan_active[ch] = 1'b0;
        end
        ADDR_EDGE_CNT: res.read_data = chan_edges[ch];
        ADDR_TS_INDEX: res.read_data = 32'(chan_ring_pos[ch]);
        ADDR_ELAPSED:  res.read_data = chan_elapsed[ch];
        ADDR_LEVEL:    res.read_data = 32'(chan_level[ch]);
        ADDR_TS_ENTRY: res.read_data = stamp_mem[ch][req.entry_index];
        default: ;
      endcase
    end
    return res;
  endfunction

  task automatic send_request(item_t req);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_if.valid       <= 1'b1;
    item_if.kind        <= req.kind;
    item_if.channel     <= req.channel;
    item_if.reg_addr    <= req.reg_addr;
    item_if.write_data  <= req.write_data;
    item_if.entry_index <= req.entry_index;
    do @(posedge clk); while (item_if.ready !== 1'b1);
    pending_results.push_back(predict_capture(req));
  endtask

  task automatic send_fields(logic [1:0] kind, logic [7:0] channel, logic [2:0] addr,
                             logic [4:0] data, logic [3:0] entry);
    item_t req;
    req.kind        = kind;
    req.channel     = channel;
    req.reg_addr    = addr;
    req.write_data  = data;
    req.entry_index = entry;
    send_request(req);
  endtask

  task automatic drop_request_line();
    @(negedge clk);
    item_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // settings change only with the unit idle
  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    drop_request_line();
    wait_drained();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    if (idx == CFG_BLOCK_ENABLE) cfg_enable = value[0];
    else if (idx == CFG_RING_SIZE) cfg_ring_size = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic item_t random_request();
    item_t req;
    int r;
    int ch;
    int written[$];
    r = $urandom_range(0, 99);
    req.kind = (r < 38) ? KIND_EDGE : (r < 62) ? KIND_WRITE : (r < 96) ? KIND_READ :
               KIND_UNUSED;
    r = $urandom_range(0, 99);
    if (r < 70) req.channel = 8'(focus_channel);
    else if (r < 90) req.channel = 8'($urandom_range(0, CHANNELS - 1));
    else req.channel = 8'($urandom_range(CHANNELS, 255));
    r = $urandom_range(0, 99);
    if (req.kind == KIND_WRITE) begin
      if (r < 45) req.reg_addr = ADDR_CONTROL;
      else if (r < 60) req.reg_addr = ADDR_EDGE_CNT;
      else if (r < 75) req.reg_addr = ADDR_LEVEL;
      else req.reg_addr = 3'($urandom_range(0, 7));
    end else begin
      req.reg_addr = (r < 25) ? ADDR_TS_ENTRY : 3'($urandom_range(0, 7));
    end
    req.write_data  = 5'($urandom_range(0, 31));
    req.entry_index = 4'($urandom_range(0, 15));
    // entries never stamped since reset must not be read
    if (req.kind == KIND_READ && req.reg_addr == ADDR_TS_ENTRY && req.channel < CHANNELS &&
        cfg_enable) begin
      ch = req.channel;
      for (int e = 0; e < RING_ENTRIES; e++)
        if (stamp_written[ch][e]) written.push_back(e);
      if (written.size() == 0) req.reg_addr = ADDR_TS_INDEX;
      else req.entry_index = 4'(written[$urandom_range(0, written.size() - 1)]);
    end
    return req;
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) focus_channel = $urandom_range(0, CHANNELS - 1);
      send_request(random_request());
    end
  endtask

  task automatic run_register_checks();
    send_fields(KIND_WRITE, 8'd0, ADDR_CONTROL, 5'h1F, 4'd0);
    send_fields(KIND_READ, 8'd0, ADDR_CONTROL, 5'd0, 4'd0);
    send_fields(KIND_WRITE, 8'd7, ADDR_LEVEL, 5'd1, 4'd0);
    send_fields(KIND_READ, 8'd7, ADDR_LEVEL, 5'd0, 4'd0);
    send_fields(KIND_WRITE, 8'd2, ADDR_STATE, 5'h1F, 4'd0);
    send_fields(KIND_READ, 8'd2, ADDR_UNUSED, 5'd0, 4'd0);
    send_fields(KIND_UNUSED, 8'd255, ADDR_UNUSED, 5'h1F, 4'd15);
    send_fields(KIND_EDGE, 8'd8, ADDR_CONTROL, 5'd0, 4'd0);
    send_fields(KIND_READ, 8'd255, ADDR_TS_ENTRY, 5'd0, 4'd15);
  endtask

  // channel 0 has all control bits set: count, stamp and latch on each edge
  task automatic run_capture_checks();
    repeat (9) send_fields(KIND_EDGE, 8'd0, ADDR_CONTROL, 5'd0, 4'd0);
    send_fields(KIND_READ, 8'd0, ADDR_TS_ENTRY, 5'd0, 4'd8);
    send_fields(KIND_READ, 8'd0, ADDR_TS_ENTRY, 5'd0, 4'd7);
    send_fields(KIND_READ, 8'd0, ADDR_TS_INDEX, 5'd0, 4'd0);
    send_fields(KIND_READ, 8'd0, ADDR_ELAPSED, 5'd0, 4'd0);
    send_fields(KIND_READ, 8'd0, ADDR_STATE, 5'd0, 4'd0);
    send_fields(KIND_READ, 8'd0, ADDR_STATE, 5'd0, 4'd0);
    send_fields(KIND_WRITE, 8'd0, ADDR_EDGE_CNT, 5'h1F, 4'd0);
    send_fields(KIND_READ, 8'd0, ADDR_EDGE_CNT, 5'd0, 4'd0);
  endtask

  task automatic run_disable_checks();
    write_setting(CFG_BLOCK_ENABLE, 5'd0);
    send_fields(KIND_EDGE, 8'd0, ADDR_CONTROL, 5'd0, 4'd0);
    send_fields(KIND_WRITE, 8'd1, ADDR_LEVEL, 5'd1, 4'd0);
    send_fields(KIND_READ, 8'd1, ADDR_LEVEL, 5'd0, 4'd0);
    send_fields(KIND_WRITE, 8'd9, ADDR_LEVEL, 5'd1, 4'd0);
    write_setting(CFG_BLOCK_ENABLE, 5'd1);
    send_fields(KIND_READ, 8'd1, ADDR_LEVEL, 5'd0, 4'd0);
  endtask

  task automatic run_random_phases();
    logic [4:0] sizes[6];
    sizes = '{5'd16, 5'd1, 5'd0, 5'd31, 5'($urandom_range(2, 15)), 5'd16};
    foreach (sizes[p]) begin
      write_setting(CFG_RING_SIZE, sizes[p]);
      no_idle = (p == 3);
      send_random(105);
      no_idle = 1'b0;
      if (p == 4) begin
        write_setting(CFG_BLOCK_ENABLE, 5'd0);
        send_random(30);
        write_setting(CFG_BLOCK_ENABLE, 5'd1);
      end
    end
  endtask

  // receiver holds off while requests keep coming, so the unit backs up
  task automatic run_backpressure();
    no_idle = 1'b1;
    hold_request = 150;
    send_random(60);
    no_idle = 1'b0;
  endtask

  initial begin
    int stall_left;
    int gap;
    stall_left = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        result_if.ready <= 1'b0;
        stall_left--;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          result_if.ready <= 1'b1;
        end else begin
          result_if.ready <= 1'b0;
          stall_left = gap - 1;
        end
      end
    end
  end

  initial begin
    capture_result_t exp;
    forever begin
      @(posedge clk);
      if (!rst && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          $error("unexpected response: read_data %0h error %0b", result_if.read_data,
                 result_if.error);
          failures++;
        end else begin
          exp = pending_results.pop_front();
          if (result_if.read_data !== exp.read_data) begin
            $error("read_data: expected %0h, got %0h", exp.read_data, result_if.read_data);
            failures++;
          end
          if (result_if.error !== exp.error) begin
            $error("error: expected %0b, got %0b", exp.error, result_if.error);
            failures++;
          end
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
          (result_if.valid === 1'b1 && result_if.ready === 1'b1) ||
          (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("** input_capture_edge_timestamp_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst                 = 1'b1;
    item_if.valid       = 1'b0;
    item_if.kind        = KIND_EDGE;
    item_if.channel     = '0;
    item_if.reg_addr    = ADDR_CONTROL;
    item_if.write_data  = '0;
    item_if.entry_index = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CFG_BLOCK_ENABLE;
    cfg_if.data         = '0;
    failures            = 0;
    no_idle             = 1'b0;
    hold_request        = 0;
    focus_channel       = 0;
    cfg_enable          = 1'b1;
    cfg_ring_size       = RING_SIZE_RST;
    global_tick         = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      chan_ctl[c]      = '0;
      chan_active[c]   = 1'b0;
      chan_edges[c]    = '0;
      chan_ring_pos[c] = '0;
      chan_elapsed[c]  = '0;
      chan_level[c]    = 1'b0;
      for (int e = 0; e < RING_ENTRIES; e++) begin
        stamp_mem[c][e]     = '0;
        stamp_written[c][e] = 1'b0;
      end
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_register_checks();
    run_capture_checks();
    run_disable_checks();
    run_random_phases();
    run_backpressure();

    drop_request_line();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("** input_capture_edge_timestamp_unit: PASSED **");
    end else begin
      $display("** input_capture_edge_timestamp_unit: FAILED **");
    end
    $finish;
  end

endmodule
